// ----- rtl/nsf_pkg.sv -----
// nsf_pkg: shared types, character codes and decode functions of the nmea sentence framer
// no dependencies; used by nsf_cfg, nsf_core and nmea_sentence_framer
package nsf_pkg;

  localparam int unsigned MAX_NAME_LEN = 7;
  localparam int unsigned NAME_SLOTS   = 7;
  localparam logic [16:0] FRAME_OVERHEAD = 17'd6;
  localparam logic [15:0] COUNT_MAX      = 16'hFFFF;
  localparam logic [15:0] MAX_BUF_RESET  = 16'd256;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CASE_MASK = 8'hDF;

  typedef enum logic [2:0] {
    ST_GOOD      = 3'd0,
    ST_BAD_SUM   = 3'd1,
    ST_BAD_NAME  = 3'd2,
    ST_NAME_LONG = 3'd3,
    ST_TOO_LONG  = 3'd4,
    ST_BAD_HEX   = 3'd5
  } status_t;

  typedef enum logic {
    REG_MAX_BUFFER_BYTES    = 1'b0,
    REG_ACCEPT_BAD_CHECKSUM = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic [15:0] max_buffer_bytes;
    logic        accept_bad_checksum;
  } cfg_t;

  function automatic logic is_preamble(input logic [7:0] b);
    return (b == CH_DOLLAR) || (b == CH_BANG);
  endfunction

  function automatic logic is_name_char(input logic [7:0] b);
    logic [7:0] up;
    up = b & CASE_MASK;
    return ((up >= 8'h41) && (up <= 8'h5A)) || ((b >= 8'h30) && (b <= 8'h39));
  endfunction

  // bit 4 set when the byte is a hex digit, low nibble its value
  function automatic logic [4:0] hex_decode(input logic [7:0] b);
    logic [7:0] v;
    v = 8'h00;
    if ((b >= 8'h30) && (b <= 8'h39)) begin
      v = b - 8'h30;
      return {1'b1, v[3:0]};
    end else if ((b >= 8'h41) && (b <= 8'h46)) begin
      v = b - 8'h37;
      return {1'b1, v[3:0]};
    end else if ((b >= 8'h61) && (b <= 8'h66)) begin
      v = b - 8'h57;
      return {1'b1, v[3:0]};
    end
    return 5'b0;
  endfunction

endpackage

// ----- rtl/nsf_byte_if.sv -----
// nsf_byte_if: valid/ready channel carrying one received byte per item
// depends on nothing
interface nsf_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

// ----- rtl/nsf_result_if.sv -----
// nsf_result_if: valid/ready channel carrying one sentence verdict per item
// depends on nothing
interface nsf_result_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [15:0] sentence_bytes;
  logic [7:0]  computed_sum;
  logic [7:0]  received_sum;
  logic [2:0]  name_count;
  logic [55:0] name_chars;

  modport source (output valid, output status, output sentence_bytes, output computed_sum,
                  output received_sum, output name_count, output name_chars, input ready);
  modport sink (input valid, input status, input sentence_bytes, input computed_sum,
                input received_sum, input name_count, input name_chars, output ready);
endinterface

// ----- rtl/nsf_cfg.sv -----
// nsf_cfg: configuration register file, written through the plain write port
// depends on nsf_pkg
module nsf_cfg (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_we,
  input  logic          cfg_index,
  input  logic [15:0]   cfg_wdata,
  output nsf_pkg::cfg_t cfg
);

  nsf_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_buffer_bytes    <= nsf_pkg::MAX_BUF_RESET;
      cfg_r.accept_bad_checksum <= 1'b0;
    end else if (cfg_we) begin
      case (nsf_pkg::reg_index_t'(cfg_index))
        nsf_pkg::REG_MAX_BUFFER_BYTES:    cfg_r.max_buffer_bytes <= cfg_wdata;
        nsf_pkg::REG_ACCEPT_BAD_CHECKSUM: cfg_r.accept_bad_checksum <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- rtl/nsf_core.sv -----
// nsf_core: per-byte framing state machine with registered result stage
// depends on nsf_pkg, nsf_byte_if and nsf_result_if
module nsf_core (
  input  logic          clk,
  input  logic          rst_n,
  input  nsf_pkg::cfg_t cfg,
  nsf_byte_if.sink      in_ch,
  nsf_result_if.source  out_ch
);

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_NAME    = 3'd1,
    PH_BODY    = 3'd2,
    PH_HEX1    = 3'd3,
    PH_HEX2    = 3'd4,
    PH_TERM    = 3'd5,
    PH_WAIT_LF = 3'd6,
    PH_WAIT_CR = 3'd7
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [7:0]  sum_r, sum_nxt;
  logic [15:0] cnt_r, cnt_nxt;
  logic [55:0] name_r, name_nxt;
  logic [3:0]  len_r, len_nxt;
  logic [7:0]  digit_r, digit_nxt;

  logic        out_valid_r;
  logic [2:0]  st_r;
  logic [15:0] o_cnt_r;
  logic [7:0]  o_sum_r;
  logic [7:0]  o_digit_r;
  logic [2:0]  o_len_r;
  logic [55:0] o_name_r;

  logic        in_fire;
  logic [7:0]  b;
  logic [15:0] cnt_inc;
  logic [4:0]  hex;
  logic        emit;
  logic        restart;
  nsf_pkg::status_t st;
  logic        sum_ok;
  phase_t      phase_mid;
  logic [7:0]  sum_mid;
  logic [15:0] cnt_mid;
  logic [55:0] name_mid;
  logic [3:0]  len_mid;
  logic [7:0]  digit_mid;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign b           = in_ch.rx_byte;
  assign cnt_inc     = (cnt_r != nsf_pkg::COUNT_MAX) ? cnt_r + 16'd1 : cnt_r;
  assign hex         = nsf_pkg::hex_decode(b);
  assign sum_ok      = (digit_r == sum_r) || cfg.accept_bad_checksum;

  always_comb begin
    phase_mid = phase_r;
    sum_mid   = sum_r;
    cnt_mid   = cnt_r;
    name_mid  = name_r;
    len_mid   = len_r;
    digit_mid = digit_r;
    emit      = 1'b0;
    restart   = 1'b0;
    st        = nsf_pkg::ST_GOOD;
    case (phase_r)
      PH_NAME: begin
        cnt_mid = cnt_inc;
        sum_mid = sum_r ^ b;
        if ((b != nsf_pkg::CH_COMMA) || (len_r == 4'd0)) begin
          if (!nsf_pkg::is_name_char(b)) begin
            emit    = 1'b1;
            restart = 1'b1;
            st      = nsf_pkg::ST_BAD_NAME;
          end else if (len_r >= 4'(nsf_pkg::MAX_NAME_LEN)) begin
            emit    = 1'b1;
            restart = 1'b1;
            st      = nsf_pkg::ST_NAME_LONG;
          end else begin
            if (len_r < 4'(nsf_pkg::NAME_SLOTS)) begin
              name_mid = name_r | ({48'b0, b} << {len_r[2:0], 3'b000});
            end
            len_mid = len_r + 4'd1;
          end
        end else begin
          phase_mid = PH_BODY;
        end
      end
      PH_BODY: begin
        cnt_mid = cnt_inc;
        if (b == nsf_pkg::CH_STAR) begin
          phase_mid = PH_HEX1;
        end else begin
          sum_mid = sum_r ^ b;
          if (({1'b0, cnt_inc} + nsf_pkg::FRAME_OVERHEAD) > {1'b0, cfg.max_buffer_bytes}) begin
            emit    = 1'b1;
            restart = 1'b1;
            st      = nsf_pkg::ST_TOO_LONG;
          end
        end
      end
      PH_HEX1, PH_HEX2: begin
        cnt_mid = cnt_inc;
        if (!hex[4]) begin
          emit    = 1'b1;
          restart = 1'b1;
          st      = nsf_pkg::ST_BAD_HEX;
        end else if (phase_r == PH_HEX1) begin
          digit_mid = {hex[3:0], 4'h0};
          phase_mid = PH_HEX2;
        end else begin
          digit_mid = digit_r | {4'h0, hex[3:0]};
          phase_mid = PH_TERM;
        end
      end
      PH_TERM: begin
        if (b == nsf_pkg::CH_CR) begin
          phase_mid = PH_WAIT_LF;
        end else if (b == nsf_pkg::CH_LF) begin
          phase_mid = PH_WAIT_CR;
        end else begin
          emit    = 1'b1;
          restart = 1'b1;
          st      = sum_ok ? nsf_pkg::ST_GOOD : nsf_pkg::ST_BAD_SUM;
        end
      end
      PH_WAIT_LF, PH_WAIT_CR: begin
        emit = 1'b1;
        st   = sum_ok ? nsf_pkg::ST_GOOD : nsf_pkg::ST_BAD_SUM;
        if (((phase_r == PH_WAIT_LF) && (b == nsf_pkg::CH_LF)) ||
            ((phase_r == PH_WAIT_CR) && (b == nsf_pkg::CH_CR))) begin
          phase_mid = PH_IDLE;
        end else begin
          restart = 1'b1;
        end
      end
      default: begin
        restart = 1'b1;
      end
    endcase
  end

  // a byte that aborts or ends a sentence, or arrives while idle, is checked again as a preamble
  always_comb begin
    phase_nxt = phase_mid;
    sum_nxt   = sum_mid;
    cnt_nxt   = cnt_mid;
    name_nxt  = name_mid;
    len_nxt   = len_mid;
    digit_nxt = digit_mid;
    if (restart) begin
      if (nsf_pkg::is_preamble(b)) begin
        phase_nxt = PH_NAME;
        cnt_nxt   = 16'd1;
        sum_nxt   = 8'h00;
        name_nxt  = 56'b0;
        len_nxt   = 4'd0;
        digit_nxt = 8'h00;
      end else begin
        phase_nxt = PH_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      sum_r       <= 8'h00;
      cnt_r       <= 16'd0;
      name_r      <= 56'b0;
      len_r       <= 4'd0;
      digit_r     <= 8'h00;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        phase_r <= phase_nxt;
        sum_r   <= sum_nxt;
        cnt_r   <= cnt_nxt;
        name_r  <= name_nxt;
        len_r   <= len_nxt;
        digit_r <= digit_nxt;
      end
      if (in_fire && emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (in_fire && emit) begin
      st_r      <= st;
      o_cnt_r   <= cnt_mid;
      o_sum_r   <= sum_mid;
      o_digit_r <= digit_mid;
      o_len_r   <= len_mid[2:0];
      o_name_r  <= name_mid;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.status         = st_r;
  assign out_ch.sentence_bytes = o_cnt_r;
  assign out_ch.computed_sum   = o_sum_r;
  assign out_ch.received_sum   = o_digit_r;
  assign out_ch.name_count     = o_len_r;
  assign out_ch.name_chars     = o_name_r;

`ifndef SYNTHESIS
  a_count_live: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r != PH_IDLE) |-> (cnt_r != 16'd0))
    else $error("sentence in progress with zero byte count");

  a_name_len: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= 4'(nsf_pkg::MAX_NAME_LEN))
    else $error("name length beyond limit");

  a_hex_low: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_HEX2) |-> (digit_r[3:0] == 4'h0))
    else $error("low checksum nibble set before second digit");

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> out_valid_r)
    else $error("input stalled with empty result stage");

  a_emit_not_idle: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(phase_r) != PH_IDLE))
    else $error("result produced from idle phase");
`endif

endmodule

// ----- rtl/nmea_sentence_framer.sv -----
// nmea_sentence_framer: top level of the nmea sentence framer
// depends on nsf_pkg, nsf_byte_if, nsf_result_if, nsf_cfg and nsf_core
//
//   channel   dir  handshake          payload
//   in_ch     in   valid/ready        rx_byte
//   out_ch    out  valid/ready        status, sentence_bytes, sums, name_count, name_chars
//   cfg_*     in   cfg_we             cfg_index, cfg_wdata
//
// one byte per cycle unless the input is stalled; the framing state updates in the cycle a byte is taken
// a result appears in the result register in the cycle after the byte that causes it is taken
// input stalls only while the result register is full and out_ch.ready is low
// synchronous active-low reset: idle phase, empty result stage, config defaults
module nmea_sentence_framer (
  input  logic         clk,
  input  logic         rst_n,
  nsf_byte_if.sink     in_ch,
  nsf_result_if.source out_ch,
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [15:0]  cfg_wdata
);

  nsf_pkg::cfg_t cfg;

  nsf_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  nsf_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

endmodule

// ----- dv/tb_nmea_sentence_framer.sv -----
// tb_nmea_sentence_framer: self-checking testbench of the nmea sentence framer
// depends on nsf_pkg, nsf_byte_if, nsf_result_if and nmea_sentence_framer
// byte stream of well-formed and broken sentences, per-byte verdict prediction, in-order check
module tb_nmea_sentence_framer;

  localparam int CLK_PERIOD   = 12;
  localparam int LIMIT_CYCLES = 300000;
  localparam int SETTLE_CYCLES = 4;
  localparam int HOLD_CYCLES  = 150;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_F  = 8'h46;
  localparam logic [7:0] CH_UP_Z  = 8'h5A;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_F  = 8'h66;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TILDE = 8'h7E;

  typedef enum logic [2:0] {
    FR_IDLE, FR_NAME, FR_BODY, FR_HEX_HI, FR_HEX_LO, FR_TERM, FR_WAIT_LF, FR_WAIT_CR
  } frame_phase_t;

  typedef struct {
    nsf_pkg::status_t status;
    logic [15:0]      sentence_bytes;
    logic [7:0]       computed_sum;
    logic [7:0]       received_sum;
    logic [2:0]       name_count;
    logic [55:0]      name_chars;
  } verdict_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                rx_valid = 1'b0;
  logic [7:0]          rx_data = 8'h00;
  logic                res_ready = 1'b0;
  logic                cfg_we = 1'b0;
  nsf_pkg::reg_index_t cfg_index = nsf_pkg::REG_MAX_BUFFER_BYTES;
  logic [15:0]         cfg_wdata = 16'h0000;

  nsf_byte_if   in_ch ();
  nsf_result_if out_ch ();

  assign in_ch.valid   = rx_valid;
  assign in_ch.rx_byte = rx_data;
  assign out_ch.ready  = res_ready;

  nmea_sentence_framer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #(CLK_PERIOD / 2) clk = 1'b1;
    #(CLK_PERIOD / 2) clk = 1'b0;
  end

  // predicted framer state and register copies
  frame_phase_t fr_phase = FR_IDLE;
  logic [7:0]   xor_sum = 8'h00;
  logic [15:0]  frame_len = 16'h0000;
  logic [63:0]  name_buf = 64'h0;
  int unsigned  name_len = 0;
  logic [7:0]   hex_sum = 8'h00;
  logic [15:0]  buf_limit = nsf_pkg::MAX_BUF_RESET;
  logic         allow_bad_sum = 1'b0;

  verdict_t     verdict_q[$];
  logic [7:0]   rx_queue[$];
  int           bytes_left = 0;
  int unsigned  bytes_pushed = 0;
  int unsigned  mismatches = 0;
  logic         rx_taken = 1'b0;
  logic         res_taken = 1'b0;
  int unsigned  rx_gap = 0;
  int unsigned  res_gap = 0;
  logic         gaps_on = 1'b1;
  int unsigned  hold_left = 0;

  function automatic int unsigned pick_gap();
    return gaps_on ? $urandom_range(0, 3) : 0;
  endfunction

  function automatic int hex_nibble(input logic [7:0] b);
    if (b >= CH_ZERO && b <= CH_NINE) return int'(b - CH_ZERO);
    if (b >= CH_UP_A && b <= CH_UP_F) return int'(b - CH_UP_A) + 10;
    if (b >= CH_LO_A && b <= CH_LO_F) return int'(b - CH_LO_A) + 10;
    return -1;
  endfunction

  task automatic post_verdict(input nsf_pkg::status_t st);
    verdict_t v;
    v.status         = st;
    v.sentence_bytes = frame_len;
    v.computed_sum   = xor_sum;
    v.received_sum   = hex_sum;
    v.name_count     = name_len[2:0];
    v.name_chars     = name_buf[55:0];
    verdict_q.push_back(v);
  endtask

  task automatic checksum_verdict();
    post_verdict((hex_sum == xor_sum || allow_bad_sum) ?
                 nsf_pkg::ST_GOOD : nsf_pkg::ST_BAD_SUM);
  endtask

  // a byte that ends or aborts a sentence may open the next one
  task automatic restart(input logic [7:0] b);
    if (b == nsf_pkg::CH_DOLLAR || b == nsf_pkg::CH_BANG) begin
      fr_phase  = FR_NAME;
      frame_len = 16'd1;
      xor_sum   = 8'h00;
      name_buf  = 64'h0;
      name_len  = 0;
      hex_sum   = 8'h00;
    end else begin
      fr_phase = FR_IDLE;
    end
  endtask

  task automatic bump_len();
    if (frame_len != nsf_pkg::COUNT_MAX) frame_len++;
  endtask

  task automatic frame_byte(input logic [7:0] b);
    logic [7:0] up;
    int         nib;
    case (fr_phase)
      FR_NAME: begin
        bump_len();
        xor_sum ^= b;
        if (b != nsf_pkg::CH_COMMA || name_len == 0) begin
          up = b & nsf_pkg::CASE_MASK;
          if (!((up >= CH_UP_A && up <= CH_UP_Z) || (b >= CH_ZERO && b <= CH_NINE))) begin
            post_verdict(nsf_pkg::ST_BAD_NAME);
            restart(b);
          end else if (name_len >= nsf_pkg::MAX_NAME_LEN) begin
            post_verdict(nsf_pkg::ST_NAME_LONG);
            restart(b);
          end else begin
            if (name_len < 8) name_buf[name_len*8 +: 8] = b;
            name_len++;
          end
        end else begin
          fr_phase = FR_BODY;
        end
      end
      FR_BODY: begin
        bump_len();
        if (b == nsf_pkg::CH_STAR) begin
          fr_phase = FR_HEX_HI;
        end else begin
          xor_sum ^= b;
          if (17'(frame_len) + nsf_pkg::FRAME_OVERHEAD > 17'(buf_limit)) begin
            post_verdict(nsf_pkg::ST_TOO_LONG);
            restart(b);
          end
        end
      end
      FR_HEX_HI, FR_HEX_LO: begin
        bump_len();
        nib = hex_nibble(b);
        if (nib < 0) begin
          post_verdict(nsf_pkg::ST_BAD_HEX);
          restart(b);
        end else if (fr_phase == FR_HEX_HI) begin
          hex_sum  = {nib[3:0], 4'h0};
          fr_phase = FR_HEX_LO;
        end else begin
          hex_sum[3:0] = nib[3:0];
          fr_phase     = FR_TERM;
        end
      end
      FR_TERM: begin
        if (b == nsf_pkg::CH_CR) begin
          fr_phase = FR_WAIT_LF;
        end else if (b == nsf_pkg::CH_LF) begin
          fr_phase = FR_WAIT_CR;
        end else begin
          checksum_verdict();
          restart(b);
        end
      end
      FR_WAIT_LF, FR_WAIT_CR: begin
        checksum_verdict();
        if ((fr_phase == FR_WAIT_LF && b == nsf_pkg::CH_LF) ||
            (fr_phase == FR_WAIT_CR && b == nsf_pkg::CH_CR))
          fr_phase = FR_IDLE;
        else
          restart(b);
      end
      default: restart(b);
    endcase
  endtask

  task automatic flag(input string what, input logic [63:0] want, input logic [63:0] got);
    mismatches++;
    if (mismatches <= 10) $display("mismatch %s: expected %h got %h", what, want, got);
  endtask

  // byte sender
  always @(negedge clk) begin : rx_driver
    logic       nxt_valid;
    logic [7:0] nxt_byte;
    nxt_valid = rx_valid;
    nxt_byte  = rx_data;
    if (rx_taken) begin
      rx_taken  = 1'b0;
      nxt_valid = 1'b0;
      rx_gap    = pick_gap();
    end
    if (!nxt_valid && rst_n) begin
      if (rx_gap != 0) begin
        rx_gap--;
      end else if (rx_queue.size() != 0) begin
        nxt_byte  = rx_queue.pop_front();
        nxt_valid = 1'b1;
      end
    end
    rx_valid <= nxt_valid;
    rx_data  <= nxt_byte;
  end

  // result receiver, long hold counted down here
  always @(negedge clk) begin : result_sink
    logic nxt_ready;
    if (res_taken) begin
      res_taken = 1'b0;
      res_gap   = pick_gap();
    end
    if (hold_left != 0) begin
      nxt_ready = 1'b0;
      hold_left--;
    end else if (res_gap != 0) begin
      nxt_ready = 1'b0;
      res_gap--;
    end else begin
      nxt_ready = 1'b1;
    end
    res_ready <= nxt_ready;
  end

  always @(posedge clk) begin : monitor
    verdict_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      res_taken = 1'b1;
      if (verdict_q.size() == 0) begin
        flag("unexpected result, status", 64'h0, 64'(out_ch.status));
      end else begin
        want = verdict_q.pop_front();
        if (out_ch.status !== want.status)
          flag("status", 64'(want.status), 64'(out_ch.status));
        if (out_ch.sentence_bytes !== want.sentence_bytes)
          flag("sentence_bytes", 64'(want.sentence_bytes), 64'(out_ch.sentence_bytes));
        if (out_ch.computed_sum !== want.computed_sum)
          flag("computed_sum", 64'(want.computed_sum), 64'(out_ch.computed_sum));
        if (out_ch.received_sum !== want.received_sum)
          flag("received_sum", 64'(want.received_sum), 64'(out_ch.received_sum));
        if (out_ch.name_count !== want.name_count)
          flag("name_count", 64'(want.name_count), 64'(out_ch.name_count));
        if (out_ch.name_chars !== want.name_chars)
          flag("name_chars", 64'(want.name_chars), 64'(out_ch.name_chars));
      end
    end
    if (rst_n && in_ch.valid && in_ch.ready) begin
      rx_taken = 1'b1;
      bytes_left--;
      frame_byte(in_ch.rx_byte);
    end
  end

  task automatic push_byte(input logic [7:0] b);
    rx_queue.push_back(b);
    bytes_left++;
    bytes_pushed++;
  endtask

  task automatic push_text(input string txt);
    for (int k = 0; k < txt.len(); k++) push_byte(txt[k]);
  endtask

  function automatic logic [7:0] name_char();
    int unsigned r;
    r = $urandom_range(0, 61);
    if (r < 10) return CH_ZERO + 8'(r);
    if (r < 36) return CH_UP_A + 8'(r - 10);
    return CH_LO_A + 8'(r - 36);
  endfunction

  function automatic logic [7:0] body_char();
    logic [7:0] c;
    c = nsf_pkg::CH_STAR;
    while (c == nsf_pkg::CH_STAR) begin
      if ($urandom_range(0, 7) == 0) c = 8'($urandom_range(0, 255));
      else c = 8'($urandom_range(CH_SPACE, CH_TILDE));
    end
    return c;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n, input logic lower);
    if (n < 10) return CH_ZERO + 8'(n);
    return (lower ? CH_LO_A : CH_UP_A) + 8'(n - 10);
  endfunction

  // mostly well-formed sentences; a share carries a broken name, sum, digit or byte
  task automatic add_sentence(input int unsigned body_max);
    logic [7:0]  s[$];
    logic [7:0]  sum;
    logic        lower;
    int unsigned kind;
    int unsigned nlen;
    int unsigned blen;
    kind  = $urandom_range(0, 99);
    lower = 1'($urandom_range(0, 1));
    s.push_back($urandom_range(0, 1) ? nsf_pkg::CH_DOLLAR : nsf_pkg::CH_BANG);
    nlen = $urandom_range(1, nsf_pkg::MAX_NAME_LEN);
    if (kind < 4) nlen = nsf_pkg::MAX_NAME_LEN + 1;
    else if (kind < 7) nlen = 0;
    for (int k = 0; k < nlen; k++) s.push_back(name_char());
    s.push_back(nsf_pkg::CH_COMMA);
    blen = $urandom_range(0, body_max);
    for (int k = 0; k < blen; k++) s.push_back(body_char());
    sum = 8'h00;
    for (int k = 1; k < s.size(); k++) sum ^= s[k];
    if (kind >= 7 && kind < 15) sum ^= 8'($urandom_range(1, 255));
    s.push_back(nsf_pkg::CH_STAR);
    s.push_back(hex_char(sum[7:4], lower));
    s.push_back(hex_char(sum[3:0], lower));
    if (kind >= 15 && kind < 20)
      s[s.size() - 1 - $urandom_range(0, 1)] = 8'($urandom_range(0, 255));
    case ($urandom_range(0, 5))
      0, 1: begin s.push_back(nsf_pkg::CH_CR); s.push_back(nsf_pkg::CH_LF); end
      2: begin s.push_back(nsf_pkg::CH_LF); s.push_back(nsf_pkg::CH_CR); end
      3: s.push_back(nsf_pkg::CH_CR);
      4: s.push_back(nsf_pkg::CH_LF);
      default: ;
    endcase
    if (kind >= 20 && kind < 25)
      s[$urandom_range(1, s.size() - 1)] = 8'($urandom_range(0, 255));
    foreach (s[k]) push_byte(s[k]);
  endtask

  task automatic add_random(input int unsigned amount, input int unsigned body_max);
    int unsigned start;
    start = bytes_pushed;
    while (bytes_pushed - start < amount) begin
      if ($urandom_range(0, 19) == 0)
        repeat ($urandom_range(1, 5)) push_byte(8'($urandom_range(0, 255)));
      add_sentence(body_max);
    end
  endtask

  task automatic settle();
    while (bytes_left != 0 || verdict_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_reg(input nsf_pkg::reg_index_t idx, input logic [15:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      nsf_pkg::REG_MAX_BUFFER_BYTES:    buf_limit = val;
      nsf_pkg::REG_ACCEPT_BAD_CHECKSUM: allow_bad_sum = val[0];
      default: ;
    endcase
  endtask

  initial begin : stimulus
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // good with cr lf, good with lf then an aborting preamble, name overflow,
    // comma first, bad hex digit, bad checksum closed by a preamble
    gaps_on = 1'b1;
    push_text("$A,*6D");
    push_byte(nsf_pkg::CH_CR);
    push_byte(nsf_pkg::CH_LF);
    push_text("!1,*1d");
    push_byte(nsf_pkg::CH_LF);
    push_text("$ABCDEFGH$,$A,*G$A,*00!");
    add_random(400, 12);
    settle();

    // six-byte buffer limit, bad sums accepted
    set_reg(nsf_pkg::REG_MAX_BUFFER_BYTES, 16'd6);
    set_reg(nsf_pkg::REG_ACCEPT_BAD_CHECKSUM, 16'd1);
    gaps_on = 1'b0;
    push_text("$A,x$A,*00");
    push_byte(nsf_pkg::CH_CR);
    push_byte(nsf_pkg::CH_LF);
    add_random(150, 3);
    settle();

    // largest buffer, receiver held off while the sender keeps offering
    set_reg(nsf_pkg::REG_MAX_BUFFER_BYTES, 16'hFFFF);
    set_reg(nsf_pkg::REG_ACCEPT_BAD_CHECKSUM, 16'd0);
    gaps_on = 1'b1;
    add_random(150, 20);
    hold_left = HOLD_CYCLES;
    while (hold_left != 0) @(negedge clk);
    add_random(150, 20);
    settle();

    set_reg(nsf_pkg::REG_MAX_BUFFER_BYTES, 16'($urandom_range(20, 60)));
    set_reg(nsf_pkg::REG_ACCEPT_BAD_CHECKSUM, 16'd1);
    add_random(350, 30);
    settle();

    if (mismatches == 0 && verdict_q.size() == 0) begin
      $display("tb_nmea_sentence_framer passed");
    end else begin
      $display("tb_nmea_sentence_framer failed");
    end
    $finish;
  end

  initial begin : watchdog
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("tb_nmea_sentence_framer failed");
    $finish;
  end

endmodule
